FILE: rtl/csm_pkg.sv
// Package for the case-insensitive substring search block.
// Holds sizing constants, command codes, the cell control word and the fold function.
// No dependencies.
package csm_pkg;

  localparam int unsigned PATTERN_MAX = 256;
  localparam int unsigned STRING_MAX  = 1024;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned POS_W  = 10;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SCAN   = 2'd2
  } cmd_e;

  // Control word broadcast to every cell of the row
  typedef struct packed {
    logic              shift;    // append: take neighbor's char, head and active
    logic              clear;    // drop the stored pattern
    logic              scan;     // update match bits with fc
    logic              restart;  // zero match bits
    logic [CHAR_W-1:0] fc;       // folded searched-string byte
  } cell_ctl_t;

  function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: rtl/case_insensitive_substring_match.sv
// Case-insensitive substring search over a byte stream, one word per cycle while not stalled.
// Throughput: one input word per cycle; input stalls only while a result is unread.
// The result is registered and appears in the cycle after the word marked last is accepted.
// The rate is set by the row of pattern cells, which all update together in the same cycle.
// Reset (async, active low) empties the pattern and the scan state; stored pattern
// bytes are not reset and are only used once written.
module case_insensitive_substring_match #(
  parameter int unsigned PATTERN_MAX = csm_pkg::PATTERN_MAX,
  parameter int unsigned STRING_MAX  = csm_pkg::STRING_MAX
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [csm_pkg::CMD_W-1:0]   command_i,
  input  logic [csm_pkg::CHAR_W-1:0]  char_value_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [csm_pkg::POS_W-1:0]   match_position_o,
  output logic                        too_long_o
);

  // Width of the pattern length (0..PATTERN_MAX), the byte offset
  // (0..STRING_MAX+1), and a start offset (0..STRING_MAX-1).
  localparam int unsigned LenW   = $clog2(PATTERN_MAX + 1);
  localparam int unsigned OffW   = $clog2(STRING_MAX + 2);
  localparam int unsigned StartW = $clog2(STRING_MAX);
  localparam int unsigned SumW   = (LenW > OffW) ? LenW : OffW;
  localparam int unsigned SatW   = (StartW > csm_pkg::POS_W) ? StartW : csm_pkg::POS_W;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic in_acc;
  logic do_clear, do_append, do_scan, do_last;

  assign in_stall_o = out_valid_o && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    do_clear  = 1'b0;
    do_append = 1'b0;
    do_scan   = 1'b0;
    if (in_acc) begin
      unique case (command_i)
        csm_pkg::CMD_CLEAR:  do_clear  = 1'b1;
        csm_pkg::CMD_APPEND: do_append = 1'b1;
        csm_pkg::CMD_SCAN:   do_scan   = 1'b1;
        default: ;  // unused code: drop the word
      endcase
    end
  end
  assign do_last = do_scan && last_i;

  // ---------------------------------------------------------------------------
  // Pattern length and scan state
  // ---------------------------------------------------------------------------
  logic [LenW-1:0]   len_q, len_d;
  logic [OffW-1:0]   off_q, off_d, off_nx;
  logic              seen_q, seen_d, seen_nx;
  logic [StartW-1:0] start_q, start_d, start_nx;
  logic              full, in_window, scan_en, hit;
  logic [SumW-1:0]   start_calc;

  assign full      = (len_q == LenW'(PATTERN_MAX));
  // Bytes past the first STRING_MAX take no part in the search
  assign in_window = (off_q < OffW'(STRING_MAX));
  assign scan_en   = do_scan && in_window && (len_q != '0);
  assign start_calc = SumW'(off_q) + SumW'(1) - SumW'(len_q);

  always_comb begin
    len_d = len_q;
    if (do_clear) begin
      len_d = '0;
    end else if (do_append && !full) begin
      len_d = len_q + LenW'(1);
    end
  end

  // The _nx values include the current word; the result is taken from them
  // before the restart that follows the last word.
  always_comb begin
    off_nx   = off_q;
    seen_nx  = seen_q;
    start_nx = start_q;
    if (scan_en && hit && !seen_q) begin
      seen_nx  = 1'b1;
      start_nx = start_calc[StartW-1:0];
    end
    // Saturate the offset at STRING_MAX+1
    if (do_scan && (off_q < OffW'(STRING_MAX + 1))) begin
      off_nx = off_q + OffW'(1);
    end
    off_d   = off_nx;
    seen_d  = seen_nx;
    start_d = start_nx;
    if (do_clear || do_append || do_last) begin
      off_d   = '0;
      seen_d  = 1'b0;
      start_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      off_q   <= '0;
      seen_q  <= 1'b0;
      start_q <= '0;
    end else begin
      len_q   <= len_d;
      off_q   <= off_d;
      seen_q  <= seen_d;
      start_q <= start_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row. Cell 0 holds the newest pattern byte; an append shifts the row
  // up by one. Cell j holds pattern byte len-1-j, so the head cell (first
  // pattern byte) sits at len-1 and the full-match bit is always in cell 0.
  // Match bits travel down from cell j+1 to cell j.
  // ---------------------------------------------------------------------------
  csm_pkg::cell_ctl_t ctl;

  logic [csm_pkg::CHAR_W-1:0] cell_char [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]     cell_head;
  logic [PATTERN_MAX-1:0]     cell_active;
  logic [PATTERN_MAX-1:0]     cell_match;
  logic [PATTERN_MAX-1:0]     cell_hit;

  assign ctl.shift   = do_append && !full;
  assign ctl.clear   = do_clear;
  assign ctl.scan    = scan_en;
  assign ctl.restart = do_clear || do_append || do_last;
  assign ctl.fc      = csm_pkg::fold(char_value_i);

  assign hit = cell_hit[0];

  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    logic [csm_pkg::CHAR_W-1:0] char_in;
    logic                       head_in;
    logic                       active_in;
    logic                       prev_in;

    if (j == 0) begin : g_first
      assign char_in   = csm_pkg::fold(char_value_i);
      assign head_in   = (len_q == '0);
      assign active_in = 1'b1;
    end else begin : g_rest
      assign char_in   = cell_char[j-1];
      assign head_in   = cell_head[j-1];
      assign active_in = cell_active[j-1];
    end

    if (j == PATTERN_MAX - 1) begin : g_end
      assign prev_in = 1'b0;
    end else begin : g_mid
      assign prev_in = cell_match[j+1];
    end

    csm_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .char_i       (char_in),
      .head_i       (head_in),
      .active_i     (active_in),
      .prev_match_i (prev_in),
      .char_o       (cell_char[j]),
      .head_o       (cell_head[j]),
      .active_o     (cell_active[j]),
      .match_o      (cell_match[j]),
      .hit_o        (cell_hit[j])
    );
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                      out_valid_q;
  logic                      found_q, found_d;
  logic [csm_pkg::POS_W-1:0] pos_q, pos_d;
  logic                      too_long_q, too_long_d;
  logic [SatW-1:0]           start_ext;

  // Empty pattern matches at offset 0; wide offsets clip to the top code
  always_comb begin
    found_d    = (len_q == '0) || seen_nx;
    start_ext  = SatW'(start_nx);
    too_long_d = (off_nx > OffW'(STRING_MAX));
    pos_d      = '0;
    if ((len_q != '0) && seen_nx) begin
      if (start_ext > SatW'(csm_pkg::POS_MAX)) begin
        pos_d = csm_pkg::POS_MAX;
      end else begin
        pos_d = start_ext[csm_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_last) begin
      found_q    <= found_d;
      pos_q      <= pos_d;
      too_long_q <= too_long_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign match_position_o = pos_q;
  assign too_long_o       = too_long_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_head_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_head))
    else $error("more than one head cell");

  a_head_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != '0) == (|cell_head))
    else $error("head cell disagrees with pattern length");

  a_seen_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (len_q != '0))
    else $error("match recorded with empty pattern");

  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_clear |=> (len_q == '0) && !cell_active[0])
    else $error("clear did not empty the pattern");

  a_notfound_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (pos_q == '0))
    else $error("position nonzero without a match");

endmodule

FILE: rtl/csm_cell.sv
// One cell of the pattern row: a folded pattern byte, head/active flags and a match bit.
// Depends on csm_pkg.
module csm_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  csm_pkg::cell_ctl_t        ctl_i,
  input  logic [csm_pkg::CHAR_W-1:0] char_i,
  input  logic                      head_i,
  input  logic                      active_i,
  input  logic                      prev_match_i,
  output logic [csm_pkg::CHAR_W-1:0] char_o,
  output logic                      head_o,
  output logic                      active_o,
  output logic                      match_o,
  output logic                      hit_o
);

  logic [csm_pkg::CHAR_W-1:0] char_q;
  logic                       head_q, head_d;
  logic                       active_q, active_d;
  logic                       match_q, match_d;

  // Prefix ending here matches when this is the head cell or the shorter prefix matched last byte
  assign hit_o = active_q && (head_q || prev_match_i) && (char_q == ctl_i.fc);

  always_comb begin
    head_d   = head_q;
    active_d = active_q;
    if (ctl_i.clear) begin
      head_d   = 1'b0;
      active_d = 1'b0;
    end else if (ctl_i.shift) begin
      head_d   = head_i;
      active_d = active_i;
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctl_i.restart) begin
      match_d = 1'b0;
    end else if (ctl_i.scan) begin
      match_d = hit_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= 1'b0;
      active_q <= 1'b0;
      match_q  <= 1'b0;
    end else begin
      head_q   <= head_d;
      active_q <= active_d;
      match_q  <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      char_q <= char_i;
    end
  end

  assign char_o   = char_q;
  assign head_o   = head_q;
  assign active_o = active_q;
  assign match_o  = match_q;

endmodule
